[rtl/imhq_pkg.sv]
package imhq_pkg;
  localparam int CAPACITY_DEF = 128;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int ID_W = 7;
  localparam int NUM_IDS = 128;
  localparam int TIME_W = 16;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXTRACT = 2'd1;
  localparam logic [1:0] REQ_HALVE   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;
endpackage

[rtl/indexed_min_heap_queue.sv]
// Channel  | handshake            | payload
// in_      | in_valid / in_ready  | req_type, job_id, start_time, job_length, rem_length
// out_     | out_valid / out_ready| status, job_id, start_time, job_length, rem_length,
//          |                      | entry_count
// Steps: an item is accepted, then read (extract, halve), then sifted up level by
// level (read parent, compare, write) or down (read left, read right, pick, write),
// as the single-port record memory serves each read/swap. A rejected item goes to
// the output right after acceptance (full, empty) or after the map read (absent id).
// After reset a clearing pass empties the id-to-slot map; no item
// is taken meanwhile. in_ready is low while an item is at work or its result
// waits in the output register; a stalled output holds the block.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic [ID_W-1:0]        in_job_id,
  input  logic [TIME_W-1:0]      in_start_time,
  input  logic [LENGTH_BITS-1:0] in_job_length,
  input  logic [LENGTH_BITS-1:0] in_rem_length,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [ID_W-1:0]        out_job_id,
  output logic [TIME_W-1:0]      out_start_time,
  output logic [LENGTH_BITS-1:0] out_job_length,
  output logic [LENGTH_BITS-1:0] out_rem_length,
  output logic [7:0]             out_entry_count
);
  localparam int SW = $clog2(CAPACITY + 1);   // slot / count width
  localparam int AW = $clog2(CAPACITY + 1);   // memory address width (slots 1..CAPACITY)

  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [TIME_W-1:0]      start;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] rem;
  } rec_t;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_RD0   = 13'b0000000000100,  // root / map data back, issue record read
    S_RD0W  = 13'b0000000001000,  // record read data back
    S_UPRP  = 13'b0000000010000,  // read parent
    S_UPCMP = 13'b0000000100000,  // compare cur with parent
    S_UPWR  = 13'b0000001000000,  // write parent to child slot
    S_DNRL  = 13'b0000010000000,  // read left child
    S_DNRR  = 13'b0000100000000,  // left data back, read right child
    S_DNCMP = 13'b0001000000000,  // right data back, pick
    S_DNWR  = 13'b0010000000000,  // write child into parent slot
    S_FIN   = 13'b0100000000000,  // write cur record to final slot
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Record memory, single port, registered read.
  rec_t         mem [1:CAPACITY];
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  rec_t         mem_wd, mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_r <= mem[mem_addr];
  end

  // Id-to-slot map, one write and one read port.
  logic [SW-1:0]   map [0:NUM_IDS-1];
  logic            map_we;
  logic [ID_W-1:0] map_wa, map_ra;
  logic [SW-1:0]   map_wd, map_rd_r;

  always_ff @(posedge clk) begin
    if (map_we) map[map_wa] <= map_wd;
    map_rd_r <= map[map_ra];
  end

  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [SW-1:0]   cur_r, cur_nxt;     // slot where the moving record sits
  rec_t            rec_r, rec_nxt;     // moving record
  rec_t            lc_r, lc_nxt;       // left child / parent held
  logic [1:0]      req_r, req_nxt;
  logic [1:0]      st_r, st_nxt;
  rec_t            got_r, got_nxt;
  logic [ID_W-1:0] clr_r, clr_nxt;

  function automatic logic goes_first(rec_t a, rec_t b);
    return (a.rem < b.rem) || (a.rem == b.rem && a.id < b.id);
  endfunction

  logic [SW:0]  left_w;
  assign left_w = {cur_r, 1'b0};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status      = st_r;
  assign out_job_id      = got_r.id;
  assign out_start_time  = got_r.start;
  assign out_job_length  = got_r.len;
  assign out_rem_length  = got_r.rem;
  assign out_entry_count = 8'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; cur_nxt = cur_r; rec_nxt = rec_r; lc_nxt = lc_r;
    req_nxt = req_r; st_nxt = st_r; got_nxt = got_r; clr_nxt = clr_r;
    mem_we = 1'b0; mem_addr = AW'(cur_r); mem_wd = rec_r;
    map_we = 1'b0; map_wa = rec_r.id; map_wd = cur_r; map_ra = in_job_id;
    unique case (state_r)
      S_CLEAR: begin
        map_we = 1'b1; map_wa = clr_r; map_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ID_W'(NUM_IDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;
          st_nxt = ST_OK;
          got_nxt = '0;
          rec_nxt = '{in_job_id, in_start_time, in_job_length, in_rem_length};
          mem_addr = AW'(1);
          state_nxt = S_OUT;
          case (in_req_type)
            REQ_INSERT: begin
              if (cnt_r >= SW'(CAPACITY)) st_nxt = ST_FULL;
              else begin
                cnt_nxt = cnt_r + 1'b1;
                cur_nxt = cnt_r + 1'b1;
                state_nxt = S_UPRP;
              end
            end
            REQ_EXTRACT: begin
              if (cnt_r == '0) st_nxt = ST_EMPTY;
              else state_nxt = S_RD0;
            end
            REQ_HALVE: state_nxt = S_RD0;
            default: ;
          endcase
        end
      end
      S_RD0: begin
        // map_rd_r valid now (halve); memory root read (extract) also done.
        if (req_r == REQ_EXTRACT) begin
          got_nxt = mem_rd_r;
          map_we = 1'b1; map_wa = mem_rd_r.id; map_wd = '0;
          mem_addr = AW'(cnt_r);
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_RD0W;
        end else begin
          if (map_rd_r == '0 || map_rd_r > cnt_r) begin
            st_nxt = ST_ABSENT; state_nxt = S_OUT;
          end else begin
            cur_nxt = map_rd_r; mem_addr = AW'(map_rd_r);
            state_nxt = S_RD0W;
          end
        end
      end
      S_RD0W: begin
        if (req_r == REQ_EXTRACT) begin
          rec_nxt = mem_rd_r;
          cur_nxt = SW'(1);
          if (cnt_r == '0) state_nxt = S_OUT;
          else state_nxt = S_DNRL;
        end else begin
          rec_nxt = mem_rd_r;
          rec_nxt.rem = mem_rd_r.rem >> 1;
          rec_nxt.len = mem_rd_r.len >> 1;
          state_nxt = S_UPRP;
        end
      end
      S_UPRP: begin
        if (cur_r <= SW'(1)) state_nxt = S_FIN;
        else begin
          mem_addr = AW'(cur_r >> 1);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        lc_nxt = mem_rd_r;
        if (goes_first(rec_r, mem_rd_r)) state_nxt = S_UPWR;
        else state_nxt = S_FIN;
      end
      S_UPWR: begin
        // hold parent in child slot, advance upward
        mem_we = 1'b1; mem_addr = AW'(cur_r); mem_wd = lc_r;
        map_we = 1'b1; map_wa = lc_r.id; map_wd = cur_r;
        cur_nxt = cur_r >> 1;
        state_nxt = S_UPRP;
      end
      S_DNRL: begin
        if (left_w > {1'b0, cnt_r}) state_nxt = S_FIN;
        else begin
          mem_addr = AW'(left_w);
          state_nxt = S_DNRR;
        end
      end
      S_DNRR: begin
        lc_nxt = mem_rd_r;
        mem_addr = AW'(left_w + 1'b1);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if ((left_w + 1'b1) <= {1'b0, cnt_r} && goes_first(mem_rd_r, lc_r)
            && goes_first(mem_rd_r, rec_r)) begin
          lc_nxt = mem_rd_r;
          cur_nxt = SW'(left_w + 1'b1);
          state_nxt = S_DNWR;
        end else if (goes_first(lc_r, rec_r)) begin
          cur_nxt = SW'(left_w);
          state_nxt = S_DNWR;
        end else state_nxt = S_FIN;
        // remember old slot in the write below via cur_r
      end
      S_DNWR: begin
        // child moves into parent slot (cur_r >> 1)
        mem_we = 1'b1; mem_addr = AW'(cur_r >> 1); mem_wd = lc_r;
        map_we = 1'b1; map_wa = lc_r.id; map_wd = cur_r >> 1;
        state_nxt = S_DNRL;
      end
      S_FIN: begin
        mem_we = 1'b1; mem_addr = AW'(cur_r); mem_wd = rec_r;
        map_we = 1'b1; map_wa = rec_r.id; map_wd = cur_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
    cur_r <= cur_nxt; rec_r <= rec_nxt; lc_r <= lc_nxt;
    req_r <= req_nxt; st_r <= st_nxt; got_r <= got_nxt;
  end
endmodule

[test/tb_indexed_min_heap_queue.sv]
module tb_indexed_min_heap_queue;
  import imhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = CAPACITY_DEF;
  localparam int LW  = LENGTH_BITS_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [LW-1:0]     len;
    logic [LW-1:0]     rem;
  } job_rec_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [LW-1:0]     len;
    logic [LW-1:0]     rem;
    logic [7:0]        count;
  } heap_result_t;

  // One directed row: request fields, then an optional typed-in result.
  typedef struct {
    logic              fixed;
    logic [1:0]        req;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [LW-1:0]     len;
    logic [LW-1:0]     rem;
    heap_result_t      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_INSERT;
  logic [ID_W-1:0] in_job_id = '0;
  logic [TIME_W-1:0] in_start_time = '0;
  logic [LW-1:0] in_job_length = '0;
  logic [LW-1:0] in_rem_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [ID_W-1:0] out_job_id;
  logic [TIME_W-1:0] out_start_time;
  logic [LW-1:0] out_job_length;
  logic [LW-1:0] out_rem_length;
  logic [7:0] out_entry_count;

  indexed_min_heap_queue u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_job_id, .in_start_time,
    .in_job_length, .in_rem_length, .out_valid, .out_ready, .out_status, .out_job_id,
    .out_start_time, .out_job_length, .out_rem_length, .out_entry_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap: slots 1..held, map from job id to slot (0 = absent).
  job_rec_t     shadow_heap [1:CAP];
  int unsigned  slot_map [NUM_IDS];
  int unsigned  held = 0;
  heap_result_t pending_results [$];
  logic         cur_fixed = 1'b0;
  heap_result_t cur_typed;

  int errors = 0;
  int items_sent = 0, results_seen = 0;
  int n_full = 0, n_empty = 0, n_absent = 0, n_extract = 0, n_halve = 0;
  int in_idle_pct = 14, out_idle_pct = 65;

  function automatic bit ranks_first(job_rec_t a, job_rec_t b);
    return (a.rem < b.rem) || (a.rem == b.rem && a.id < b.id);
  endfunction

  function automatic void swap_recs(int unsigned p, int unsigned q);
    job_rec_t t;
    t = shadow_heap[p];
    shadow_heap[p] = shadow_heap[q];
    shadow_heap[q] = t;
    slot_map[shadow_heap[p].id] = p;
    slot_map[shadow_heap[q].id] = q;
  endfunction

  function automatic void bubble_up(int unsigned i);
    while (i > 1 && ranks_first(shadow_heap[i], shadow_heap[i/2])) begin
      swap_recs(i, i/2);
      i = i / 2;
    end
  endfunction

  function automatic void bubble_down(int unsigned i);
    int unsigned best, l, r;
    forever begin
      best = i;
      l = 2 * i;
      r = l + 1;
      if (l <= held && ranks_first(shadow_heap[l], shadow_heap[best])) best = l;
      if (r <= held && ranks_first(shadow_heap[r], shadow_heap[best])) best = r;
      if (best == i) return;
      swap_recs(i, best);
      i = best;
    end
  endfunction

  // Apply one request to the shadow heap and return the result it yields.
  function automatic heap_result_t heap_apply(logic [1:0] req, logic [ID_W-1:0] id,
                                              logic [TIME_W-1:0] st, logic [LW-1:0] len,
                                              logic [LW-1:0] rem);
    heap_result_t r;
    int unsigned s;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (held >= CAP) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          held++;
          shadow_heap[held] = '{id: id, start: st, len: len, rem: rem};
          slot_map[id] = held;
          bubble_up(held);
        end
      end
      REQ_EXTRACT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          n_extract++;
          r.id = shadow_heap[1].id;
          r.start = shadow_heap[1].start;
          r.len = shadow_heap[1].len;
          r.rem = shadow_heap[1].rem;
          slot_map[shadow_heap[1].id] = 0;
          shadow_heap[1] = shadow_heap[held];
          held--;
          if (held > 0) begin
            slot_map[shadow_heap[1].id] = 1;
            bubble_down(1);
          end
        end
      end
      REQ_HALVE: begin
        s = slot_map[id];
        if (s == 0 || s > held) begin
          r.status = ST_ABSENT;
          n_absent++;
        end else begin
          n_halve++;
          shadow_heap[s].rem = shadow_heap[s].rem >> 1;
          shadow_heap[s].len = shadow_heap[s].len >> 1;
          bubble_up(s);
        end
      end
      default: ;
    endcase
    r.count = held[7:0];
    return r;
  endfunction

  // Check the result channel first, then predict the item taken on this edge.
  always @(posedge clk) begin
    heap_result_t e, p;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_job_id !== e.id) begin
          $error("job_id exp %0d got %0d", e.id, out_job_id); errors++;
        end
        if (out_start_time !== e.start) begin
          $error("start_time exp %0h got %0h", e.start, out_start_time); errors++;
        end
        if (out_job_length !== e.len) begin
          $error("job_length exp %0h got %0h", e.len, out_job_length); errors++;
        end
        if (out_rem_length !== e.rem) begin
          $error("rem_length exp %0h got %0h", e.rem, out_rem_length); errors++;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, out_entry_count); errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      // Keep the shadow heap in step even where the row carries a typed result.
      p = heap_apply(in_req_type, in_job_id, in_start_time, in_job_length, in_rem_length);
      pending_results.push_back(cur_fixed ? cur_typed : p);
    end
  end

  // Receiver stalls at random; change only on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Present one item and hold it until taken; return at the next falling edge.
  task automatic send_item(logic [1:0] req, logic [ID_W-1:0] id, logic [TIME_W-1:0] st,
                           logic [LW-1:0] len, logic [LW-1:0] rem, logic fixed,
                           heap_result_t typed);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur_fixed <= fixed;
    cur_typed <= typed;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_job_id <= id;
    in_start_time <= st;
    in_job_length <= len;
    in_rem_length <= rem;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  dir_row_t dir_rows [$];

  function automatic dir_row_t mk(logic fixed, logic [1:0] req, logic [ID_W-1:0] id,
                                  logic [TIME_W-1:0] st, logic [LW-1:0] len,
                                  logic [LW-1:0] rem, heap_result_t res);
    dir_row_t d;
    d.fixed = fixed; d.req = req; d.id = id; d.start = st; d.len = len; d.rem = rem;
    d.res = res;
    return d;
  endfunction

  initial begin
    int mode, pick, seg;
    logic [1:0] rq;
    logic [ID_W-1:0] rid;
    logic [LW-1:0] rrem;
    heap_result_t none;
    none = '0;
    foreach (slot_map[k]) slot_map[k] = 0;

    // Empty heap: extract and halve report status only.
    dir_rows.push_back(mk(1, REQ_EXTRACT, 0, 0, 0, 0, '{ST_EMPTY, 0, 0, 0, 0, 0}));
    dir_rows.push_back(mk(1, REQ_HALVE, 5, 0, 0, 0, '{ST_ABSENT, 0, 0, 0, 0, 0}));
    // Field extremes, then a tie on the key broken by the smaller id.
    dir_rows.push_back(mk(1, REQ_INSERT, 127, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          '{ST_OK, 0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(1, REQ_INSERT, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 2}));
    dir_rows.push_back(mk(1, REQ_INSERT, 64, 16'h1234, 16'h0FF0, 0, '{ST_OK, 0, 0, 0, 0, 3}));
    // Unused request code changes nothing.
    dir_rows.push_back(mk(1, REQ_UNUSED, 127, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          '{ST_OK, 0, 0, 0, 0, 3}));
    dir_rows.push_back(mk(1, REQ_HALVE, 127, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 3}));
    dir_rows.push_back(mk(1, REQ_EXTRACT, 0, 0, 0, 0, '{ST_OK, 0, 0, 0, 0, 2}));
    dir_rows.push_back(mk(1, REQ_EXTRACT, 0, 0, 0, 0,
                          '{ST_OK, 64, 16'h1234, 16'h0FF0, 0, 1}));
    dir_rows.push_back(mk(1, REQ_EXTRACT, 0, 0, 0, 0,
                          '{ST_OK, 127, 16'hFFFF, 16'h7FFF, 16'h7FFF, 0}));
    dir_rows.push_back(mk(1, REQ_EXTRACT, 0, 0, 0, 0, '{ST_EMPTY, 0, 0, 0, 0, 0}));
    // Duplicate ids, halving to zero, stale map entries.
    dir_rows.push_back(mk(0, REQ_INSERT, 3, 16'h0011, 16'h00C8, 16'd100, none));
    dir_rows.push_back(mk(0, REQ_INSERT, 3, 16'h0022, 16'h0064, 16'd50, none));
    dir_rows.push_back(mk(0, REQ_HALVE, 3, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_INSERT, 9, 16'h5555, 16'hAAAA, 16'd1, none));
    dir_rows.push_back(mk(0, REQ_HALVE, 9, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_HALVE, 9, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_EXTRACT, 0, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_EXTRACT, 0, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_HALVE, 3, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_EXTRACT, 0, 0, 0, 0, none));
    dir_rows.push_back(mk(0, REQ_INSERT, 42, 16'hAAAA, 16'h5555, 16'hAAAA, none));
    dir_rows.push_back(mk(0, REQ_EXTRACT, 0, 0, 0, 0, none));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].id, dir_rows[i].start, dir_rows[i].len,
                dir_rows[i].rem, dir_rows[i].fixed, dir_rows[i].res);

    // Random part in segments: fill, fill, drain, drain, mixed, so the heap
    // reaches full and empty repeatedly.
    seg = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        in_idle_pct = 65; out_idle_pct = 14;
      end
      if (n == 2 * RAND_ITEMS / 3) begin
        in_idle_pct = 0; out_idle_pct = 0;
      end
      if (n == RAND_ITEMS / 2) begin
        // Hold off until the block has drained every result.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (n % 150 == 0) seg++;
      mode = seg % 5;
      pick = $urandom_range(99);
      if (pick < 3) rq = REQ_UNUSED;
      else if (mode < 2) rq = (pick < 80) ? REQ_INSERT : (pick < 90) ? REQ_EXTRACT : REQ_HALVE;
      else if (mode < 4) rq = (pick < 75) ? REQ_EXTRACT : (pick < 88) ? REQ_INSERT : REQ_HALVE;
      else rq = (pick < 40) ? REQ_INSERT : (pick < 70) ? REQ_EXTRACT : REQ_HALVE;
      rid = $urandom_range(1) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
      rrem = $urandom_range(1) ? LW'($urandom_range(7)) : LW'($urandom);
      send_item(rq, rid, TIME_W'($urandom), LW'($urandom), rrem, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d items, checked %0d results: %0d extracts, %0d halvings",
             items_sent, results_seen, n_extract, n_halve);
    $display("Status cases seen: %0d full, %0d empty, %0d absent id",
             n_full, n_empty, n_absent);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

[filelist.f]
rtl/imhq_pkg.sv
rtl/indexed_min_heap_queue.sv
test/tb_indexed_min_heap_queue.sv
